// ===== hw/rtl/vfd_double_buffered_scan_controller_top_defines.svh =====
// Assertion macros for the display scan controller RTL.
// Each macro expects clk and rst in scope of the including module.
`ifndef VFD_DOUBLE_BUFFERED_SCAN_CONTROLLER_TOP_DEFINES_SVH
`define VFD_DOUBLE_BUFFERED_SCAN_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define VFDSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vfdsc: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define VFDSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vfdsc: next-cycle check failed");

`endif

// ===== hw/rtl/vfdsc_pkg.sv =====
// Shared types, constants and the pixel address map of the display scan controller.
// No dependencies; used by every module of the block.
package vfdsc_pkg;

  // Fixed display geometry
  localparam int COLUMN_COUNT = 16;
  localparam int PIXEL_COUNT  = 105;
  localparam int BUF_WORDS    = 120;
  localparam int DRIVER_BITS  = 6;

  // Interleaving formula constants
  localparam int ADDR_LOW_LIMIT = 35;
  localparam int ADDR_MID_LIMIT = 70;
  localparam int ADDR_BASE_A    = 51;
  localparam int ADDR_BASE_B    = 52;
  localparam int ADDR_OFFSET    = 15;

  // Field widths
  localparam int IDX_W    = 7;
  localparam int BANK_W   = 3;
  localparam int PIN_W    = 5;
  localparam int COL_W    = 4;
  localparam int ADDR_W   = 8;

  // Op queue between parser and scan engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POWER = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic KIND_SHIFT = 1'b0;
  localparam logic KIND_POWER = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [BANK_W-1:0] bank;
    logic [PIN_W-1:0]  offset;
    logic [15:0]       data;
    logic              store;
    logic              swap;
    logic              enable;
  } vfdsc_op_t;

  // Interleaved buffer address of pixel index i (modular 8-bit math)
  function automatic logic [ADDR_W-1:0] pixel_address(input logic [IDX_W-1:0] i);
    logic [ADDR_W-1:0] half_up;
    logic [ADDR_W-1:0] half_dn;
    logic [ADDR_W-1:0] v;
    half_up = (ADDR_W'(i) + ADDR_W'(1)) >> 1;
    half_dn = ADDR_W'(i) >> 1;
    if (i < IDX_W'(ADDR_LOW_LIMIT)) begin
      v = i[0] ? ADDR_W'(ADDR_BASE_A) - half_up : ADDR_W'(ADDR_BASE_A) + half_dn;
    end else if (i < IDX_W'(ADDR_MID_LIMIT)) begin
      v = i[0] ? ADDR_W'(ADDR_BASE_A) + half_up : ADDR_W'(ADDR_BASE_A) - half_dn;
    end else begin
      v = i[0] ? ADDR_W'(ADDR_BASE_B) - half_up : ADDR_W'(ADDR_BASE_B) + half_dn;
    end
    return v + ADDR_W'(ADDR_OFFSET);
  endfunction

endpackage

// ===== hw/rtl/vfd_double_buffered_scan_controller_top.sv =====
// Top level of the double-buffered display scan controller.
// A scan tick passes the op queue; the scan engine pops it, then reads the per-driver
// buffer banks once per pin via a read register into the output register, one word
// per cycle while result_stall is low. A power byte passes the op queue to the output
// register; serial bytes are taken one per cycle while the 4-entry op queue has room.
// Reset (synchronous, rst high) blanks both buffers via valid bits.
module vfd_double_buffered_scan_controller_top import vfdsc_pkg::*; #(
  parameter int SHIFT_LENGTH = 20,
  parameter int DRIVER_COUNT = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   cmd,
  input  logic [7:0]             rx_byte,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   kind,
  output logic                   grid_on,
  output logic [DRIVER_BITS-1:0] pixel_bits,
  output logic                   last,
  output logic                   dcdc_enable
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  vfdsc_op_t push_op;
  vfdsc_op_t head_op;

  // Parse items into ops
  vfdsc_front #(
    .SHIFT_LENGTH (SHIFT_LENGTH),
    .DRIVER_COUNT (DRIVER_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  // Buffer ops between the two sides
  vfdsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  // Carry out ops and drive results
  vfdsc_back #(
    .SHIFT_LENGTH (SHIFT_LENGTH),
    .DRIVER_COUNT (DRIVER_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_op         (head_op),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .grid_on      (grid_on),
    .pixel_bits   (pixel_bits),
    .last         (last),
    .dcdc_enable  (dcdc_enable)
  );

endmodule

// ===== hw/rtl/vfdsc_front.sv =====
// Command byte parser: classifies items and turns them into queue ops.
// Depends on vfdsc_pkg.
module vfdsc_front import vfdsc_pkg::*; #(
  parameter int SHIFT_LENGTH = 20,
  parameter int DRIVER_COUNT = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  logic      cmd,
  input  logic [7:0] rx_byte,
  input  logic      q_full,
  output logic      q_push,
  output vfdsc_op_t q_op
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_POWER = 2'd1;
  localparam logic [1:0] MODE_HIGH  = 2'd2;
  localparam logic [1:0] MODE_LOW   = 2'd3;

  localparam logic [7:0] CMD_POWER = 8'h00;
  localparam logic [7:0] CMD_FRAME = 8'h01;

  localparam logic [ADDR_W:0] BANKED_WORDS = (ADDR_W+1)'(DRIVER_COUNT * SHIFT_LENGTH);

  logic [1:0]       mode, mode_next;
  logic [IDX_W-1:0] load_index, load_index_next;
  logic [7:0]       high_byte_hold, high_byte_hold_next;
  logic             power_enable, power_enable_next;

  logic              accept;
  logic              last_word;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W:0]   addr_ext;
  logic [ADDR_W:0]   bank_base;
  logic [BANK_W-1:0] bank;
  logic              store;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign last_word  = load_index == IDX_W'(PIXEL_COUNT - 1);

  // Map the pixel index to a driver bank and an offset within it
  always_comb begin
    pix_addr  = pixel_address(load_index);
    addr_ext  = {1'b0, pix_addr};
    bank      = '0;
    bank_base = '0;
    for (int d = 1; d < DRIVER_COUNT; d++) begin
      if (addr_ext >= (ADDR_W+1)'(d * SHIFT_LENGTH)) begin
        bank      = BANK_W'(d);
        bank_base = (ADDR_W+1)'(d * SHIFT_LENGTH);
      end
    end
    store = (pix_addr < ADDR_W'(BUF_WORDS)) && (addr_ext < BANKED_WORDS);
  end

  // Parse the byte stream and build the op for the queue
  always_comb begin
    mode_next           = mode;
    load_index_next     = load_index;
    high_byte_hold_next = high_byte_hold;
    power_enable_next   = power_enable;
    q_push              = 1'b0;
    q_op                = '0;
    if (accept) begin
      if (cmd) begin
        q_push      = 1'b1;
        q_op.op     = OP_TICK;
        q_op.enable = power_enable;
      end else begin
        unique case (mode)
          MODE_IDLE: begin
            if (rx_byte == CMD_POWER) begin
              mode_next = MODE_POWER;
            end else if (rx_byte == CMD_FRAME) begin
              mode_next       = MODE_HIGH;
              load_index_next = '0;
            end
          end
          MODE_POWER: begin
            power_enable_next = rx_byte != 8'd0;
            mode_next         = MODE_IDLE;
            q_push            = 1'b1;
            q_op.op           = OP_POWER;
            q_op.enable       = power_enable_next;
          end
          MODE_HIGH: begin
            high_byte_hold_next = rx_byte;
            mode_next           = MODE_LOW;
          end
          MODE_LOW: begin
            q_push      = 1'b1;
            q_op.op     = OP_WRITE;
            q_op.bank   = bank;
            q_op.offset = PIN_W'(addr_ext - bank_base);
            q_op.data   = {high_byte_hold, rx_byte};
            q_op.store  = store;
            q_op.swap   = last_word;
            q_op.enable = power_enable;
            if (last_word) begin
              mode_next       = MODE_IDLE;
              load_index_next = '0;
            end else begin
              mode_next       = MODE_HIGH;
              load_index_next = load_index + IDX_W'(1);
            end
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      load_index     <= '0;
      high_byte_hold <= '0;
      power_enable   <= 1'b0;
    end else begin
      mode           <= mode_next;
      load_index     <= load_index_next;
      high_byte_hold <= high_byte_hold_next;
      power_enable   <= power_enable_next;
    end
  end

endmodule

// ===== hw/rtl/vfdsc_queue.sv =====
// Short op queue that decouples the parser from the scan engine.
// Depends on vfdsc_pkg.
module vfdsc_queue import vfdsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vfdsc_op_t push_op,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output vfdsc_op_t head_op
);

  vfdsc_op_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = entries[rd_ptr];

  // Store pushed ops
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/vfdsc_back.sv =====
// Scan engine: banked double frame buffer, buffer writes, swap, column shift-out.
// Depends on vfdsc_pkg and the assertion macro header.
`include "vfd_double_buffered_scan_controller_top_defines.svh"

module vfdsc_back import vfdsc_pkg::*; #(
  parameter int SHIFT_LENGTH = 20,
  parameter int DRIVER_COUNT = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  vfdsc_op_t              q_op,
  output logic                   q_pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   kind,
  output logic                   grid_on,
  output logic [DRIVER_BITS-1:0] pixel_bits,
  output logic                   last,
  output logic                   dcdc_enable
);

  logic             front_select;
  logic [COL_W-1:0] scan_column;
  logic             busy;
  logic [PIN_W-1:0] pin;
  logic [COL_W-1:0] tick_col;
  logic             tick_en;

  logic             rd_pending;
  logic             rd_grid;
  logic             rd_last;
  logic [COL_W-1:0] rd_col;
  logic             rd_en;

  logic                    out_free;
  logic                    consume;
  logic                    issue;
  logic                    head_power;
  logic                    wr_en;
  logic                    wr_buf;
  logic [DRIVER_COUNT-1:0] pix_now;
  logic [DRIVER_BITS-1:0]  pix_out;

  assign out_free   = !result_valid || !result_stall;
  assign consume    = rd_pending && out_free;
  assign issue      = busy && (!rd_pending || consume);
  assign head_power = q_op.op == OP_POWER;
  assign q_pop      = q_valid && !busy && (!head_power || (!rd_pending && out_free));
  assign wr_en      = q_pop && (q_op.op == OP_WRITE) && q_op.store;
  assign wr_buf     = !front_select;

  // One bank per pixel driver: word d*SHIFT_LENGTH+pin of each buffer
  for (genvar d = 0; d < DRIVER_COUNT; d++) begin : g_bank
    logic [15:0]             mem [2][SHIFT_LENGTH];
    logic [SHIFT_LENGTH-1:0] vld [2];
    logic [15:0]             word_q;
    logic                    ok_q;

    // Write the back buffer, read the front buffer
    always_ff @(posedge clk) begin
      if (wr_en && (q_op.bank == BANK_W'(d))) begin
        mem[wr_buf][q_op.offset] <= q_op.data;
      end
      if (issue) begin
        word_q <= mem[front_select][pin];
        ok_q   <= vld[front_select][pin];
      end
    end

    // Mark written words; unwritten words read as blank
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[0] <= '0;
        vld[1] <= '0;
      end else if (wr_en && (q_op.bank == BANK_W'(d))) begin
        vld[wr_buf][q_op.offset] <= 1'b1;
      end
    end

    assign pix_now[d] = ok_q && word_q[~rd_col];
  end

  // Fit the driver bits to the output field
  for (genvar k = 0; k < DRIVER_BITS; k++) begin : g_pix
    if (k < DRIVER_COUNT) begin : g_used
      assign pix_out[k] = pix_now[k];
    end else begin : g_unused
      assign pix_out[k] = 1'b0;
    end
  end

  // Sequence the ops: writes, swap, ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      front_select <= 1'b0;
      scan_column  <= '0;
      busy         <= 1'b0;
      pin          <= '0;
      tick_col     <= '0;
      tick_en      <= 1'b0;
    end else begin
      if (q_pop && (q_op.op == OP_WRITE) && q_op.swap) begin
        front_select <= !front_select;
      end
      if (q_pop && (q_op.op == OP_TICK)) begin
        busy     <= 1'b1;
        pin      <= '0;
        tick_col <= scan_column;
        tick_en  <= q_op.enable;
        if (scan_column >= COL_W'(COLUMN_COUNT - 1)) begin
          scan_column <= '0;
        end else begin
          scan_column <= scan_column + COL_W'(1);
        end
      end else if (issue) begin
        pin <= pin + PIN_W'(1);
        if (pin == PIN_W'(SHIFT_LENGTH - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Track read data waiting for the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else if (issue) begin
      rd_pending <= 1'b1;
    end else if (consume) begin
      rd_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_grid <= {1'b0, pin} == ({2'b00, tick_col} + (PIN_W+1)'(2));
      rd_last <= pin == PIN_W'(SHIFT_LENGTH - 1);
      rd_col  <= tick_col;
      rd_en   <= tick_en;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume || (q_pop && head_power)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      kind        <= KIND_SHIFT;
      grid_on     <= rd_grid;
      pixel_bits  <= pix_out;
      last        <= rd_last;
      dcdc_enable <= rd_en;
    end else if (q_pop && head_power) begin
      kind        <= KIND_POWER;
      grid_on     <= 1'b0;
      pixel_bits  <= '0;
      last        <= 1'b0;
      dcdc_enable <= q_op.enable;
    end
  end

  `VFDSC_ASSERT_IMP(a_busy_end, $fell(busy), $past(pin) == PIN_W'(SHIFT_LENGTH - 1))
  `VFDSC_ASSERT_IMP(a_rd_source, $rose(rd_pending), $past(issue))
  `VFDSC_ASSERT_IMP(a_write_idle, wr_en, !issue)
  `VFDSC_ASSERT_NXT(a_power_out, q_pop && head_power, result_valid && (kind == KIND_POWER))

endmodule

// ===== sim/vfd_double_buffered_scan_controller_top_tb.sv =====
// Self-checking testbench for the double-buffered display scan controller.
// Depends on vfdsc_pkg and vfd_double_buffered_scan_controller_top; predicts every shift
// and power word in its own model of the parser, frame buffers and scan column.
module vfd_double_buffered_scan_controller_top_tb import vfdsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHIFT_LEN   = 20;
  localparam int DRIVERS     = 6;
  localparam int GAP_MAX     = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 470;
  localparam int FRAME_ITEMS  = 232;
  localparam int ITEM_SLACK   = 40;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_POWER,
    PARSE_HIGH,
    PARSE_LOW
  } parse_state_e;

  typedef struct packed {
    logic                   kind;
    logic                   grid_on;
    logic [DRIVER_BITS-1:0] pixel_bits;
    logic                   last;
    logic                   dcdc_enable;
  } drive_word_t;

  typedef struct {
    logic        cmd;
    logic [7:0]  rx_byte;
    int unsigned gap;
    bit          drain;
    bit          hold_rx;
  } serial_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic       cmd          = 1'b0;
  logic [7:0] rx_byte      = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic                   kind;
  logic                   grid_on;
  logic [DRIVER_BITS-1:0] pixel_bits;
  logic                   last;
  logic                   dcdc_enable;

  vfd_double_buffered_scan_controller_top #(
    .SHIFT_LENGTH(SHIFT_LEN),
    .DRIVER_COUNT(DRIVERS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .rx_byte(rx_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .grid_on(grid_on),
    .pixel_bits(pixel_bits),
    .last(last),
    .dcdc_enable(dcdc_enable)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow state of the display controller
  logic [15:0]  frame_mem [0:1][0:BUF_WORDS-1];
  logic         shown_bank  = 1'b0;
  parse_state_e parse_state = PARSE_IDLE;
  logic [6:0]   word_index  = '0;
  logic [7:0]   high_byte   = '0;
  logic [3:0]   scan_col    = '0;
  logic         power_on    = 1'b0;

  drive_word_t  expected_words [$];
  int unsigned  words_predicted = 0;
  int unsigned  words_checked   = 0;
  int unsigned  fail_count      = 0;

  serial_item_t pending_items [$];
  int unsigned  stim_count = 0;

  // Buffer address of pixel word idx under the interleaving map
  function automatic int interleave_addr(input int idx);
    int up;
    int dn;
    int v;
    up = (idx + 1) / 2;
    dn = idx / 2;
    if (idx < ADDR_LOW_LIMIT) begin
      v = (idx % 2 == 1) ? ADDR_BASE_A - up : ADDR_BASE_A + dn;
    end else if (idx < ADDR_MID_LIMIT) begin
      v = (idx % 2 == 1) ? ADDR_BASE_A + up : ADDR_BASE_A - dn;
    end else begin
      v = (idx % 2 == 1) ? ADDR_BASE_B - up : ADDR_BASE_B + dn;
    end
    return ADDR_OFFSET + v;
  endfunction

  // Advance the shadow state by one serial transaction and queue the words it yields
  task automatic predict_display(input logic is_tick, input logic [7:0] b);
    drive_word_t            w;
    logic [15:0]            col_mask;
    logic [DRIVER_BITS-1:0] pix;
    int                     a;
    logic                   back;
    if (is_tick) begin
      col_mask = 16'h8000 >> scan_col;
      for (int pin = 0; pin < SHIFT_LEN; pin++) begin
        pix = '0;
        for (int d = 0; d < DRIVERS; d++) begin
          a = d * SHIFT_LEN + pin;
          if (a < BUF_WORDS && (frame_mem[shown_bank][a] & col_mask) != 16'h0000) begin
            pix[d] = 1'b1;
          end
        end
        w.kind        = KIND_SHIFT;
        w.grid_on     = (pin == int'(scan_col) + 2);
        w.pixel_bits  = pix;
        w.last        = (pin == SHIFT_LEN - 1);
        w.dcdc_enable = power_on;
        expected_words.push_back(w);
        words_predicted++;
      end
      scan_col = (scan_col == 4'(COLUMN_COUNT - 1)) ? 4'd0 : scan_col + 4'd1;
    end else begin
      case (parse_state)
        PARSE_IDLE: begin
          if (b == 8'd0) begin
            parse_state = PARSE_POWER;
          end else if (b == 8'd1) begin
            parse_state = PARSE_HIGH;
            word_index  = '0;
          end
        end
        PARSE_POWER: begin
          power_on      = (b != 8'd0);
          parse_state   = PARSE_IDLE;
          w.kind        = KIND_POWER;
          w.grid_on     = 1'b0;
          w.pixel_bits  = '0;
          w.last        = 1'b0;
          w.dcdc_enable = power_on;
          expected_words.push_back(w);
          words_predicted++;
        end
        PARSE_HIGH: begin
          high_byte   = b;
          parse_state = PARSE_LOW;
        end
        default: begin
          a    = interleave_addr(int'(word_index));
          back = ~shown_bank;
          if (a >= 0 && a < BUF_WORDS) begin
            frame_mem[back][a] = {high_byte, b};
          end
          if (int'(word_index) >= PIXEL_COUNT - 1) begin
            shown_bank  = back;
            parse_state = PARSE_IDLE;
            word_index  = '0;
          end else begin
            word_index  = word_index + 7'd1;
            parse_state = PARSE_HIGH;
          end
        end
      endcase
    end
  endtask

  task automatic push_item(input logic c, input logic [7:0] b, input int unsigned g,
                           input bit dr, input bit hr);
    serial_item_t it;
    it.cmd     = c;
    it.rx_byte = b;
    it.gap     = g;
    it.drain   = dr;
    it.hold_rx = hr;
    pending_items.push_back(it);
    stim_count++;
  endtask

  function automatic int unsigned draw_gap(input bit tight);
    return tight ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Driver: present queued transactions, each after its own idle gap
  serial_item_t staged;
  bit           staged_ok   = 1'b0;
  int unsigned  staged_wait = 0;
  bit           cur_hold    = 1'b0;
  logic         hold_go     = 1'b0;
  logic         feed_idle   = 1'b0;

  always @(posedge clk) begin : feed
    logic offer;
    logic take_hold;
    offer     = item_valid;
    take_hold = 1'b0;
    if (rst) begin
      item_valid <= 1'b0;
      hold_go    <= 1'b0;
      feed_idle  <= 1'b0;
    end else begin
      // Record the accepted transaction in the shadow model
      if (item_valid && !item_stall) begin
        predict_display(cmd, rx_byte);
        take_hold = cur_hold;
        offer     = 1'b0;
      end
      if (!offer) begin
        if (!staged_ok && pending_items.size() != 0) begin
          staged      = pending_items.pop_front();
          staged_ok   = 1'b1;
          staged_wait = staged.gap;
        end
        if (staged_ok) begin
          if (staged_wait != 0) begin
            staged_wait--;
          end else if (!staged.drain || words_checked == words_predicted) begin
            offer     = 1'b1;
            cmd      <= staged.cmd;
            rx_byte  <= staged.rx_byte;
            cur_hold  = staged.hold_rx;
            staged_ok = 1'b0;
          end
        end
      end
      item_valid <= offer;
      hold_go    <= take_hold;
      feed_idle  <= !offer && !staged_ok && pending_items.size() == 0;
    end
  end

  // Long receiver hold-off, started by a flagged transaction
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: compare each accepted result with the oldest prediction
  int unsigned rx_wait     = 0;
  int unsigned fast_left   = 0;

  always @(posedge clk) begin : watch
    drive_word_t w;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          $error("result transaction with nothing predicted: kind %0d", kind);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          check_field("kind", w.kind, kind);
          check_field("grid_on", w.grid_on, grid_on);
          check_field("pixel_bits", w.pixel_bits, pixel_bits);
          check_field("last", w.last, last);
          check_field("dcdc_enable", w.dcdc_enable, dcdc_enable);
          words_checked <= words_checked + 1;
        end
        // Draw the stall before the next result, with occasional stall-free stretches
        if (fast_left == 0 && $urandom_range(0, 39) == 0) begin
          fast_left = 60;
        end
        if (fast_left != 0) begin
          fast_left--;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, GAP_MAX);
        end
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      result_stall <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    bit          tight;
    int unsigned sel;
    int unsigned frames;
    int unsigned burst;
    logic [15:0] pw;
    frames = 0;
    for (int bk = 0; bk < 2; bk++) begin
      for (int i = 0; i < BUF_WORDS; i++) begin
        frame_mem[bk][i] = 16'h0000;
      end
    end

    // Directed: blank scan, power off/on, 0xFF power byte, unknown commands, column wrap
    push_item(1'b1, 8'hFF, 0, 1'b0, 1'b0);
    push_item(1'b0, 8'h00, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'h00, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'h00, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'hFF, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'h02, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'hFF, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'h80, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'h00, draw_gap(0), 1'b0, 1'b0);
    push_item(1'b0, 8'h01, draw_gap(0), 1'b0, 1'b0);
    for (int t = 0; t < 15; t++) begin
      push_item(1'b1, (t % 2 == 0) ? 8'h00 : 8'hFF, draw_gap(t < 6), 1'b0, 1'b0);
    end

    // Pause for all results, then hold the receiver while ticks pile up
    push_item(1'b1, 8'($urandom), 0, 1'b1, 1'b1);
    for (int t = 0; t < 11; t++) begin
      push_item(1'b1, 8'($urandom), 0, 1'b0, 1'b0);
    end

    // Random mix; reserve room so that two frame loads fit the item budget
    while (stim_count < RANDOM_ITEMS || frames < 2) begin
      tight = ($urandom_range(0, 3) == 0);
      sel   = $urandom_range(0, 19);
      if (frames < 2 && (sel < 2 ||
          stim_count + FRAME_ITEMS * (2 - frames) >= RANDOM_ITEMS + ITEM_SLACK)) begin
        // Frame load, with ticks mixed in, then a full scan cycle
        push_item(1'b0, 8'h01, draw_gap(tight), $urandom_range(0, 9) == 0, 1'b0);
        for (int i = 0; i < PIXEL_COUNT; i++) begin
          case ($urandom_range(0, 7))
            0:       pw = 16'hFFFF;
            1:       pw = 16'h0000;
            default: pw = 16'($urandom);
          endcase
          if (i == 0) begin
            pw = 16'h0001;
          end
          if ($urandom_range(0, 24) == 0) begin
            push_item(1'b1, 8'($urandom), draw_gap(tight), 1'b0, 1'b0);
          end
          push_item(1'b0, pw[15:8], draw_gap(tight), 1'b0, 1'b0);
          push_item(1'b0, pw[7:0], draw_gap(tight), 1'b0, 1'b0);
        end
        for (int t = 0; t < COLUMN_COUNT; t++) begin
          push_item(1'b1, 8'($urandom), draw_gap(tight), 1'b0, 1'b0);
        end
        frames++;
      end else if (sel < 6) begin
        // Power command with an edge or random level byte
        push_item(1'b0, 8'h00, draw_gap(tight), $urandom_range(0, 9) == 0, 1'b0);
        case ($urandom_range(0, 3))
          0:       push_item(1'b0, 8'h00, draw_gap(tight), 1'b0, 1'b0);
          1:       push_item(1'b0, 8'hFF, draw_gap(tight), 1'b0, 1'b0);
          default: push_item(1'b0, 8'($urandom), draw_gap(tight), 1'b0, 1'b0);
        endcase
      end else if (sel < 8) begin
        // Unknown command byte: dropped by the parser
        push_item(1'b0, 8'($urandom_range(2, 255)), draw_gap(tight), 1'b0, 1'b0);
      end else begin
        burst = $urandom_range(1, 20);
        for (int t = 0; t < burst; t++) begin
          push_item(1'b1, 8'($urandom), draw_gap(tight), t == 0 && $urandom_range(0, 9) == 0,
                    1'b0);
        end
      end
    end

    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for the feed to empty and every prediction to be matched
    @(posedge clk);
    while (!(feed_idle && words_checked == words_predicted)) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vfdsc_pkg.sv
hw/rtl/vfdsc_front.sv
hw/rtl/vfdsc_queue.sv
hw/rtl/vfdsc_back.sv
hw/rtl/vfd_double_buffered_scan_controller_top.sv
sim/vfd_double_buffered_scan_controller_top_tb.sv
